>>> rtl/core/limit_switch_actuator_fsm_top_assert.svh
// Assertion macros for the actuator sequencer.
`ifndef LIMIT_SWITCH_ACTUATOR_FSM_TOP_ASSERT_SVH
`define LIMIT_SWITCH_ACTUATOR_FSM_TOP_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define LSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define LSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LSA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define LSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/lsafsm_pkg.sv
`default_nettype none

package lsafsm_pkg;

    // Largest step count a move may command.
    localparam logic [15:0] MAX_MOVE_STEPS = 16'd65535;

    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [1:0] CMD_OTHER = 2'd0;
    localparam logic [1:0] CMD_OPEN  = 2'd1;
    localparam logic [1:0] CMD_CLOSE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_MOVE_STEPS   = 3'd0,
        CFG_MOVE_TIMEOUT     = 3'd1,
        CFG_SPEED_LIMIT      = 3'd2,
        CFG_ACCEL_LIMIT      = 3'd3,
        CFG_OPEN_IS_NEGATIVE = 3'd4
    } t_cfg_idx;

    typedef enum logic [6:0] {
        MODE_IDLE       = 7'b000_0001,
        MODE_MOV_OPEN   = 7'b000_0010,
        MODE_MOV_CLOSED = 7'b000_0100,
        MODE_AT_OPEN    = 7'b000_1000,
        MODE_AT_CLOSED  = 7'b001_0000,
        MODE_TIMEOUT    = 7'b010_0000,
        MODE_ESTOP      = 7'b100_0000
    } t_mode;

    localparam logic [2:0] CODE_IDLE       = 3'd0;
    localparam logic [2:0] CODE_MOV_OPEN   = 3'd1;
    localparam logic [2:0] CODE_MOV_CLOSED = 3'd2;
    localparam logic [2:0] CODE_AT_OPEN    = 3'd3;
    localparam logic [2:0] CODE_AT_CLOSED  = 3'd4;
    localparam logic [2:0] CODE_TIMEOUT    = 3'd5;
    localparam logic [2:0] CODE_ESTOP      = 3'd6;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [1:0]  cmd_code;
        logic        cmd_write;
        logic        closed_detected;
        logic        open_detected;
        logic        estop_on;
    } t_in_item;

    typedef struct packed {
        logic               closed_seen;
        logic               open_seen;
        logic [15:0]        accel_out;
        logic [15:0]        speed_out;
        logic               load_limits;
        logic               halt_at_end;
        logic signed [16:0] move_steps;
        logic               move_start;
        logic               motor_enable;
        logic [2:0]         state_code;
    } t_out_item;

    function automatic logic [2:0] mode_code(input t_mode mode);
        logic [2:0] code;
        unique case (mode)
            MODE_IDLE:       code = CODE_IDLE;
            MODE_MOV_OPEN:   code = CODE_MOV_OPEN;
            MODE_MOV_CLOSED: code = CODE_MOV_CLOSED;
            MODE_AT_OPEN:    code = CODE_AT_OPEN;
            MODE_AT_CLOSED:  code = CODE_AT_CLOSED;
            MODE_TIMEOUT:    code = CODE_TIMEOUT;
            MODE_ESTOP:      code = CODE_ESTOP;
            default:         code = CODE_ESTOP;
        endcase
        return code;
    endfunction

    // Signed step count of a full move towards the open or the closed end.
    function automatic logic signed [16:0] steps_for(input logic [15:0] max_steps,
                                                     input logic to_open,
                                                     input logic open_neg);
        logic [15:0] mag;
        logic        positive;
        mag      = (max_steps > MAX_MOVE_STEPS) ? MAX_MOVE_STEPS : max_steps;
        positive = to_open ^ open_neg;
        return positive ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/limit_switch_actuator_fsm_top.sv
// Sequencer for a stepper actuator that runs between an open and a closed end sensor.
// Input stream: one request per control tick carrying the estop level, both end
// sensors, an optional command write and the millisecond time. Output stream: one
// result per request with the new state, enable level, move start and step count,
// abrupt-stop and limit-load pulses, the limit values and the sensor echoes.
// The configuration channel writes the step count, timeout, speed and acceleration
// limits and the direction sense; it is always ready and should be used while idle.
// The state machine update and the result are computed in the accepting cycle and
// appear in the output register on the next edge.
// Throughput is one request per cycle; the output register is the only stage, so a
// new request is taken whenever it is empty or being drained in the same cycle.
// When the receiver stalls the result is held and requests are refused until it
// is taken; no request is lost or duplicated.
// A synchronous active-low reset returns the machine to idle with no command
// pending, clears all configuration registers and empties the output register.
`default_nettype none

module limit_switch_actuator_fsm_top
    import lsafsm_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // bit 0 estop_on, 1 open_detected, 2 closed_detected, 3 cmd_write,
    // 5:4 cmd_code, 37:6 now_ms, 39:38 zero
    input  wire  [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  wire                   i_m_axis_tready,
    // bits 2:0 state_code, 3 motor_enable, 4 move_start, 21:5 move_steps,
    // 22 halt_at_end, 23 load_limits, 39:24 speed_out, 55:40 accel_out,
    // 56 open_seen, 57 closed_seen, 63:58 zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    t_in_item    in_item;
    t_out_item   res;
    logic        in_acc;

    logic [15:0] r_max_steps;
    logic [15:0] r_timeout;
    logic [15:0] r_speed;
    logic [15:0] r_accel;
    logic        r_open_neg;

    t_mode       r_mode, n_mode, mode_e;
    logic        r_pending, n_pending, pend;
    logic [1:0]  r_last, n_last, last;
    logic [31:0] r_start_time, n_start_time;
    logic        r_enable, n_enable;

    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        start, stop, load, hit;
    logic signed [16:0] steps;
    logic [31:0] elapsed;

    assign in_item         = t_in_item'(i_s_axis_tdata[$bits(t_in_item)-1:0]);
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= '0;
            r_timeout   <= '0;
            r_speed     <= '0;
            r_accel     <= '0;
            r_open_neg  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_MOVE_STEPS:   r_max_steps <= i_cfg_data;
                CFG_MOVE_TIMEOUT:     r_timeout   <= i_cfg_data;
                CFG_SPEED_LIMIT:      r_speed     <= i_cfg_data;
                CFG_ACCEL_LIMIT:      r_accel     <= i_cfg_data;
                CFG_OPEN_IS_NEGATIVE: r_open_neg  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // A command written in this tick is visible to the state that runs in it.
    assign pend    = r_pending || in_item.cmd_write;
    assign last    = in_item.cmd_write ? in_item.cmd_code : r_last;
    assign mode_e  = in_item.estop_on ? MODE_ESTOP : r_mode;
    assign elapsed = in_item.now_ms - r_start_time;

    always_comb begin
        n_mode       = mode_e;
        n_pending    = pend;
        n_last       = last;
        n_start_time = r_start_time;
        n_enable     = r_enable;
        start        = 1'b0;
        stop         = 1'b0;
        load         = 1'b0;
        steps        = '0;
        hit          = 1'b0;
        unique case (mode_e)
            MODE_IDLE: begin
                n_enable = 1'b0;
                if (pend) begin
                    n_pending = 1'b0;
                    load      = 1'b1;
                    if (last == CMD_OPEN) begin
                        n_enable = 1'b1;
                        if (in_item.open_detected) begin
                            n_mode = MODE_AT_OPEN;
                        end else begin
                            steps        = steps_for(r_max_steps, 1'b1, r_open_neg);
                            start        = 1'b1;
                            n_start_time = in_item.now_ms;
                            n_mode       = MODE_MOV_OPEN;
                        end
                    end else if (last == CMD_CLOSE) begin
                        n_enable = 1'b1;
                        if (in_item.closed_detected) begin
                            n_mode = MODE_AT_CLOSED;
                        end else begin
                            steps        = steps_for(r_max_steps, 1'b0, r_open_neg);
                            start        = 1'b1;
                            n_start_time = in_item.now_ms;
                            n_mode       = MODE_MOV_CLOSED;
                        end
                    end
                end
            end
            MODE_MOV_OPEN, MODE_MOV_CLOSED: begin
                hit = (mode_e == MODE_MOV_OPEN) ? in_item.open_detected
                                                : in_item.closed_detected;
                // Reaching the sensor takes precedence over the timeout.
                if (hit) begin
                    stop   = 1'b1;
                    n_mode = (mode_e == MODE_MOV_OPEN) ? MODE_AT_OPEN : MODE_AT_CLOSED;
                end else if (elapsed > {16'd0, r_timeout}) begin
                    n_enable = 1'b0;
                    n_mode   = MODE_TIMEOUT;
                end
            end
            MODE_AT_OPEN: begin
                if (!in_item.open_detected) begin
                    n_mode = MODE_IDLE;
                end
                if (pend && last == CMD_CLOSE) begin
                    n_pending    = 1'b0;
                    steps        = steps_for(r_max_steps, 1'b0, r_open_neg);
                    start        = 1'b1;
                    n_start_time = in_item.now_ms;
                    n_mode       = MODE_MOV_CLOSED;
                end
            end
            MODE_AT_CLOSED: begin
                if (!in_item.closed_detected) begin
                    n_mode = MODE_IDLE;
                end
                if (pend && last == CMD_OPEN) begin
                    n_pending    = 1'b0;
                    steps        = steps_for(r_max_steps, 1'b1, r_open_neg);
                    start        = 1'b1;
                    n_start_time = in_item.now_ms;
                    n_mode       = MODE_MOV_OPEN;
                end
            end
            MODE_TIMEOUT: begin
                n_enable = 1'b0;
            end
            MODE_ESTOP: begin
                n_enable  = 1'b0;
                n_pending = 1'b0;
                if (!in_item.estop_on) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_enable  = 1'b0;
                n_pending = 1'b0;
                n_mode    = MODE_ESTOP;
            end
        endcase

        res.state_code   = mode_code(n_mode);
        res.motor_enable = n_enable;
        res.move_start   = start;
        res.move_steps   = steps;
        res.halt_at_end  = stop;
        res.load_limits  = load;
        res.speed_out    = load ? r_speed : 16'd0;
        res.accel_out    = load ? r_accel : 16'd0;
        res.open_seen    = in_item.open_detected;
        res.closed_seen  = in_item.closed_detected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_pending    <= 1'b0;
            r_last       <= CMD_OTHER;
            r_start_time <= '0;
            r_enable     <= 1'b0;
        end else if (in_acc) begin
            r_mode       <= n_mode;
            r_pending    <= n_pending;
            r_last       <= n_last;
            r_start_time <= n_start_time;
            r_enable     <= n_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - $bits(t_out_item)){1'b0}}, r_out_data};

    `include "limit_switch_actuator_fsm_top_assert.svh"

    `LSA_ASSERT_SAME(a_estop_safe, i_clk, i_rst_n, r_mode == MODE_ESTOP, !r_enable && !r_pending, "estop with motor enabled or command pending")
    `LSA_ASSERT_SAME(a_timeout_off, i_clk, i_rst_n, r_mode == MODE_TIMEOUT, !r_enable, "motor enabled in timeout state")
    `LSA_ASSERT_NEXT(a_estop_entry, i_clk, i_rst_n, in_acc && in_item.estop_on, r_mode == MODE_ESTOP && r_out_data.state_code == CODE_ESTOP, "estop request did not reach estop state")

endmodule

`default_nettype wire

>>> bench/actuator_tick_checker.sv
`default_nettype none

module actuator_tick_checker
    import lsafsm_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    input  wire                   i_s_tready,
    input  wire  [IN_DATA_W-1:0]  i_s_tdata,
    input  wire                   i_m_tvalid,
    input  wire                   i_m_tready,
    input  wire  [OUT_DATA_W-1:0] i_m_tdata,
    input  wire                   i_cfg_valid,
    input  wire                   i_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_moves
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_W = $bits(t_out_item);

    // Shadow copy of the configuration registers.
    logic [15:0] full_steps_q;
    logic [15:0] timeout_ms_q;
    logic [15:0] speed_q;
    logic [15:0] accel_q;
    logic        open_neg_q;

    // Shadow copy of the sequencer state.
    logic [2:0]  seq_mode;
    logic        cmd_pending;
    logic [1:0]  cmd_last;
    logic [31:0] move_t0;
    logic        drive_en;

    t_out_item   expected_ticks[$];

    // Signed step count of a full move towards one end, wrapped to 17 bits.
    function automatic logic [16:0] full_move(input logic to_open);
        logic [15:0] mag;
        logic        fwd;
        mag = (full_steps_q > MAX_MOVE_STEPS) ? MAX_MOVE_STEPS : full_steps_q;
        fwd = to_open ? !open_neg_q : open_neg_q;
        return fwd ? {1'b0, mag} : 17'd0 - {1'b0, mag};
    endfunction

    function automatic t_out_item advance_sequencer(input t_in_item tick);
        t_out_item r;
        logic      hit;
        r = '0;
        if (tick.cmd_write) begin
            cmd_pending = 1'b1;
            cmd_last    = tick.cmd_code;
        end
        if (tick.estop_on && seq_mode != CODE_ESTOP) begin
            seq_mode = CODE_ESTOP;
        end
        case (seq_mode)
            CODE_IDLE: begin
                drive_en = 1'b0;
                if (cmd_pending) begin
                    cmd_pending   = 1'b0;
                    r.load_limits = 1'b1;
                    if (cmd_last == CMD_OPEN) begin
                        drive_en = 1'b1;
                        if (tick.open_detected) begin
                            seq_mode = CODE_AT_OPEN;
                        end else begin
                            r.move_steps = full_move(1'b1);
                            r.move_start = 1'b1;
                            move_t0      = tick.now_ms;
                            seq_mode     = CODE_MOV_OPEN;
                        end
                    end else if (cmd_last == CMD_CLOSE) begin
                        drive_en = 1'b1;
                        if (tick.closed_detected) begin
                            seq_mode = CODE_AT_CLOSED;
                        end else begin
                            r.move_steps = full_move(1'b0);
                            r.move_start = 1'b1;
                            move_t0      = tick.now_ms;
                            seq_mode     = CODE_MOV_CLOSED;
                        end
                    end
                end
            end
            CODE_MOV_OPEN, CODE_MOV_CLOSED: begin
                hit = (seq_mode == CODE_MOV_OPEN) ? tick.open_detected : tick.closed_detected;
                // Reaching the end sensor takes priority over the timeout.
                if (hit) begin
                    r.halt_at_end = 1'b1;
                    seq_mode = (seq_mode == CODE_MOV_OPEN) ? CODE_AT_OPEN : CODE_AT_CLOSED;
                end else if (tick.now_ms - move_t0 > {16'd0, timeout_ms_q}) begin
                    drive_en = 1'b0;
                    seq_mode = CODE_TIMEOUT;
                end
            end
            CODE_AT_OPEN: begin
                if (!tick.open_detected) begin
                    seq_mode = CODE_IDLE;
                end
                if (cmd_pending && cmd_last == CMD_CLOSE) begin
                    cmd_pending  = 1'b0;
                    r.move_steps = full_move(1'b0);
                    r.move_start = 1'b1;
                    move_t0      = tick.now_ms;
                    seq_mode     = CODE_MOV_CLOSED;
                end
            end
            CODE_AT_CLOSED: begin
                if (!tick.closed_detected) begin
                    seq_mode = CODE_IDLE;
                end
                if (cmd_pending && cmd_last == CMD_OPEN) begin
                    cmd_pending  = 1'b0;
                    r.move_steps = full_move(1'b1);
                    r.move_start = 1'b1;
                    move_t0      = tick.now_ms;
                    seq_mode     = CODE_MOV_OPEN;
                end
            end
            CODE_TIMEOUT: begin
                drive_en = 1'b0;
            end
            default: begin
                drive_en    = 1'b0;
                cmd_pending = 1'b0;
                if (!tick.estop_on) begin
                    seq_mode = CODE_IDLE;
                end
            end
        endcase
        r.state_code   = seq_mode;
        r.motor_enable = drive_en;
        r.speed_out    = r.load_limits ? speed_q : 16'd0;
        r.accel_out    = r.load_limits ? accel_q : 16'd0;
        r.open_seen    = tick.open_detected;
        r.closed_seen  = tick.closed_detected;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("Result %0d: %s expected 0x%0h, got 0x%0h",
                         o_checked, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            full_steps_q = '0;
            timeout_ms_q = '0;
            speed_q      = '0;
            accel_q      = '0;
            open_neg_q   = 1'b0;
            seq_mode     = CODE_IDLE;
            cmd_pending  = 1'b0;
            cmd_last     = CMD_OTHER;
            move_t0      = '0;
            drive_en     = 1'b0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_MOVE_STEPS:   full_steps_q = i_cfg_data;
                    CFG_MOVE_TIMEOUT:     timeout_ms_q = i_cfg_data;
                    CFG_SPEED_LIMIT:      speed_q      = i_cfg_data;
                    CFG_ACCEL_LIMIT:      accel_q      = i_cfg_data;
                    CFG_OPEN_IS_NEGATIVE: open_neg_q   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_out_item'(i_m_tdata[ITEM_W-1:0]);
                if (expected_ticks.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("Result 0x%0h arrived with no request outstanding",
                                 i_m_tdata);
                    end
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("state_code", 32'(want.state_code), 32'(got.state_code));
                    check_field("motor_enable", 32'(want.motor_enable),
                                32'(got.motor_enable));
                    check_field("move_start", 32'(want.move_start), 32'(got.move_start));
                    check_field("move_steps", 32'(want.move_steps), 32'(got.move_steps));
                    check_field("halt_at_end", 32'(want.halt_at_end),
                                32'(got.halt_at_end));
                    check_field("load_limits", 32'(want.load_limits),
                                32'(got.load_limits));
                    check_field("speed_out", 32'(want.speed_out), 32'(got.speed_out));
                    check_field("accel_out", 32'(want.accel_out), 32'(got.accel_out));
                    check_field("open_seen", 32'(want.open_seen), 32'(got.open_seen));
                    check_field("closed_seen", 32'(want.closed_seen),
                                32'(got.closed_seen));
                    check_field("padding", 32'd0, 32'(i_m_tdata[OUT_DATA_W-1:ITEM_W]));
                    if (want.move_start) begin
                        o_moves++;
                    end
                    o_checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                expected_ticks.push_back(
                    advance_sequencer(t_in_item'(i_s_tdata[$bits(t_in_item)-1:0])));
            end
        end
        o_pending = expected_ticks.size();
    end

endmodule

`default_nettype wire

>>> bench/tb_top.sv
`default_nettype none

module tb_top
    import lsafsm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT   = 200000;
    localparam int         PHASES        = 6;
    localparam int         PHASE_TICKS   = 300;
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    wire                   s_tready;
    wire                   m_tvalid;
    wire  [OUT_DATA_W-1:0] m_tdata;
    wire                   cfg_ready;

    int fail_count;
    int pending;
    int checked;
    int moves;

    int cycles = 0;
    int ticks_sent = 0;
    int settings = 0;
    bit gaps_on = 1'b1;

    // Simple plant: the actuator travels for a while after a command and then
    // trips the sensor at the far end.
    logic [31:0] clock_ms;
    logic        open_flag = 1'b0;
    logic        closed_flag = 1'b0;
    logic        heading_open = 1'b0;
    int          travel_left = 0;
    int          estop_left = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    limit_switch_actuator_fsm_top u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    actuator_tick_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_moves      (moves)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding", pending);
            $display("limit_switch_actuator_fsm_top verification failed");
            $finish;
        end
    end

    // Receiver: random stalls while gaps are enabled.
    initial begin
        forever begin
            @(negedge clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    function automatic t_in_item mk_tick(input logic estop, input logic op,
                                         input logic cl, input logic wr,
                                         input logic [1:0] code, input logic [31:0] now);
        t_in_item it;
        it.estop_on        = estop;
        it.open_detected   = op;
        it.closed_detected = cl;
        it.cmd_write       = wr;
        it.cmd_code        = code;
        it.now_ms          = now;
        return it;
    endfunction

    function automatic t_in_item next_tick();
        t_in_item it;
        int       pick;
        it = '0;
        if (estop_left == 0 && $urandom_range(0, 99) < 2) begin
            estop_left = $urandom_range(1, 4);
        end
        it.estop_on = (estop_left != 0);
        if (estop_left != 0) begin
            estop_left--;
        end
        if ($urandom_range(0, 99) < 12) begin
            it.cmd_write = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                it.cmd_code  = CMD_OPEN;
                heading_open = 1'b1;
                travel_left  = $urandom_range(1, 15);
            end else if (pick < 8) begin
                it.cmd_code  = CMD_CLOSE;
                heading_open = 1'b0;
                travel_left  = $urandom_range(1, 15);
            end else begin
                it.cmd_code = (pick == 8) ? CMD_OTHER : CMD_UNDEFINED;
            end
        end
        if (travel_left != 0) begin
            travel_left--;
            // Leave the end we started from, then arrive at the other one.
            if (heading_open) begin
                closed_flag = 1'b0;
                open_flag   = (travel_left == 0);
            end else begin
                open_flag   = 1'b0;
                closed_flag = (travel_left == 0);
            end
        end
        if ($urandom_range(0, 99) < 4) begin
            open_flag = !open_flag;
        end
        if ($urandom_range(0, 99) < 4) begin
            closed_flag = !closed_flag;
        end
        clock_ms = clock_ms + (($urandom_range(0, 99) < 2) ? $urandom
                                                             : 32'($urandom_range(0, 3)));
        it.open_detected   = open_flag;
        it.closed_detected = closed_flag;
        it.now_ms          = clock_ms;
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_tick(input t_in_item it);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(it);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic load_setting(input logic [15:0] steps, input logic [15:0] tmo,
                                input logic [15:0] speed, input logic [15:0] accel,
                                input logic [15:0] dir);
        write_reg(CFG_MAX_MOVE_STEPS, steps);
        write_reg(CFG_MOVE_TIMEOUT, tmo);
        write_reg(CFG_SPEED_LIMIT, speed);
        write_reg(CFG_ACCEL_LIMIT, accel);
        write_reg(CFG_OPEN_IS_NEGATIVE, dir);
        // An index past the last register must leave everything unchanged.
        write_reg(CFG_OPEN_IS_NEGATIVE + 3'($urandom_range(1, 3)), 16'($urandom));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        clock_ms = $urandom;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        load_setting(16'hFFFF, 16'd5, 16'hFFFF, 16'h0000, 16'h0000);

        // Directed walk through the special cases.
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_OTHER, 32'h0000_0000));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_UNDEFINED, 32'h0000_0000));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_OPEN, 32'hFFFF_FFFE));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'hFFFF_FFFF));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0003));
        // Sensor and timeout in the same tick: the sensor wins.
        send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0004));
        send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b1, CMD_OPEN, 32'h0000_0008));
        // Close accepted in the tick the open sensor is lost.
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_CLOSE, 32'h0000_000A));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0010));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_OPEN, 32'h0000_0011));
        send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0012));
        send_tick(mk_tick(1'b1, 1'b0, 1'b0, 1'b1, CMD_CLOSE, 32'h0000_0013));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0014));
        send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b1, CMD_CLOSE, 32'h0000_0015));
        send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b1, CMD_OTHER, 32'h0000_0016));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0017));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0018));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b1, CMD_CLOSE, 32'h8000_0000));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b0, CMD_OTHER, 32'h8000_0001));
        // Leaving estop discards a command written in the same tick.
        send_tick(mk_tick(1'b0, 1'b1, 1'b1, 1'b1, CMD_OPEN, 32'h8000_0002));
        send_tick(mk_tick(1'b0, 1'b0, 1'b1, 1'b1, CMD_OPEN, 32'hFFFF_FFFF));
        send_tick(mk_tick(1'b0, 1'b1, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0000));
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, CMD_OTHER, 32'h0000_0001));

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                default: load_setting(16'($urandom), 16'($urandom_range(0, phase * 20)),
                                      16'($urandom), 16'($urandom), 16'($urandom));
            endcase
            gaps_on = (phase != PHASES - 1);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (phase == 2 && n == PHASE_TICKS / 2) begin
                    drain();
                end
                send_tick(next_tick());
            end
        end

        drain();
        repeat (4) @(negedge clk);
        $display("Sent %0d control ticks under %0d register settings; %0d results checked,",
                 ticks_sent, settings, checked);
        $display("%0d of them starting a move, %0d mismatches.", moves, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("limit_switch_actuator_fsm_top verification clean");
        end else begin
            $display("limit_switch_actuator_fsm_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> limit_switch_actuator_fsm_top.f
+incdir+rtl/core
rtl/core/lsafsm_pkg.sv
rtl/core/limit_switch_actuator_fsm_top.sv
bench/actuator_tick_checker.sv
bench/tb_top.sv
